// ===== design/vult_pkg.sv =====
`default_nettype none

package vult_pkg;

   localparam int VIDEO_MEM_DEPTH  = 8192;
   localparam int SPRITE_MEM_DEPTH = 160;
   localparam int VIDEO_AW         = $clog2(VIDEO_MEM_DEPTH);
   localparam int SPRITE_AW        = $clog2(SPRITE_MEM_DEPTH);

   localparam int REG_COUNT = 12;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam logic [REG_AW-1:0] REG_STAT = REG_AW'(1);
   localparam logic [REG_AW-1:0] REG_LINE = REG_AW'(4);

   localparam logic [15:0] VIDEO_BASE  = 16'h8000;
   localparam logic [15:0] SPRITE_BASE = 16'hFE00;
   localparam logic [15:0] REG_BASE    = 16'hFF40;
   localparam logic [15:0] REG_LAST    = 16'hFF4B;

   localparam int DOTS_PER_LINE = 456;
   localparam int DOT_W         = $clog2(DOTS_PER_LINE);
   localparam int SUM_W         = DOT_W + 1;

   localparam logic [7:0]       VBLANK_LINE    = 8'd144;
   localparam logic [7:0]       LAST_LINE_WRAP = 8'd154;
   localparam logic [DOT_W-1:0] SCAN_END       = DOT_W'(80);
   localparam logic [DOT_W-1:0] DRAW_END       = DOT_W'(252);

   localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_SCAN   = 2'd2,
      MODE_DRAW   = 2'd3
   } video_mode_type;

   typedef enum logic [1:0] {
      SRC_VIDEO  = 2'd0,
      SRC_SPRITE = 2'd1,
      SRC_LOCAL  = 2'd2
   } read_src_type;

   typedef struct packed {
      logic [7:0]     rd_byte;
      logic           irq;
      video_mode_type mode;
      logic [7:0]     line;
   } regs_status_type;

endpackage

`default_nettype wire

// ===== design/vult_req_if.sv =====
`default_nettype none

interface vult_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  write_byte;
   logic [8:0]  elapsed_cycles;

   modport source (output valid, action, address, write_byte, elapsed_cycles, input ready);
   modport sink (input valid, action, address, write_byte, elapsed_cycles, output ready);
endinterface

`default_nettype wire

// ===== design/vult_rsp_if.sv =====
`default_nettype none

interface vult_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       vblank_irq;
   logic [1:0] video_mode;
   logic [7:0] line_number;

   modport source (output valid, read_byte, vblank_irq, video_mode, line_number, input ready);
   modport sink (input valid, read_byte, vblank_irq, video_mode, line_number, output ready);
endinterface

`default_nettype wire

// ===== design/video_unit_bus_and_line_timing.sv =====
// Video unit bus side and line timing. Each transaction on req_ch is a bus read, a bus
// write or a timing tick, and gives exactly one transaction on rsp_ch with the
// read byte (0xFF unless a mapped read), the vblank pulse, the mode and the line
// number after it. One transaction is taken every cycle unless the read stage and the
// unread output register are both full; the video or sprite memory read is registered
// in the read stage, then the result sits in an output register so the next
// transaction enters while it waits. Each one makes at most one access to a single-port
// memory or one update of the registers and dot counter. No clearing pass after reset:
// the user must read memory entries only after writing them; the block does not enforce it.
`default_nettype none

module video_unit_bus_and_line_timing (
   input wire logic clock,
   input wire logic reset,
   vult_req_if.sink   req_ch,
   vult_rsp_if.source rsp_ch
);
   import vult_pkg::*;

   logic accept;
   logic out_free;
   logic s1_adv;

   logic [15:0]          v_off;
   logic [15:0]          s_off;
   logic                 v_hit;
   logic                 s_hit;
   logic                 is_read;
   logic                 is_write;
   logic                 v_en;
   logic                 s_en;
   logic [7:0]           v_rdata;
   logic [7:0]           s_rdata;
   regs_status_type      status;
   read_src_type         src;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   read_src_type         s1_src_ff;
   logic [7:0]           s1_byte_ff;
   logic                 s1_irq_ff;
   video_mode_type       s1_mode_ff;
   logic [7:0]           s1_line_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [7:0]           out_byte_ff;
   logic [7:0]           out_byte_in;
   logic                 out_irq_ff;
   video_mode_type       out_mode_ff;
   logic [7:0]           out_line_ff;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_read  = req_ch.action == ACT_READ;
   assign is_write = req_ch.action == ACT_WRITE;
   assign v_off    = req_ch.address - VIDEO_BASE;
   assign s_off    = req_ch.address - SPRITE_BASE;
   assign v_hit    = (req_ch.address >= VIDEO_BASE) && (32'(v_off) < VIDEO_MEM_DEPTH);
   assign s_hit    = (req_ch.address >= SPRITE_BASE) && (32'(s_off) < SPRITE_MEM_DEPTH);
   assign v_en     = accept && v_hit && (is_read || is_write);
   assign s_en     = accept && s_hit && (is_read || is_write);

   vult_ram #(.WIDTH(8), .DEPTH(VIDEO_MEM_DEPTH)) u_video_ram (
      .clock (clock),
      .en    (v_en),
      .we    (is_write),
      .addr  (v_off[VIDEO_AW-1:0]),
      .wdata (req_ch.write_byte),
      .rdata (v_rdata)
   );

   vult_ram #(.WIDTH(8), .DEPTH(SPRITE_MEM_DEPTH)) u_sprite_ram (
      .clock (clock),
      .en    (s_en),
      .we    (is_write),
      .addr  (s_off[SPRITE_AW-1:0]),
      .wdata (req_ch.write_byte),
      .rdata (s_rdata)
   );

   vult_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .action         (req_ch.action),
      .address        (req_ch.address),
      .write_byte     (req_ch.write_byte),
      .elapsed_cycles (req_ch.elapsed_cycles),
      .status         (status)
   );

   always_comb begin
      if (is_read && v_hit) begin
         src = SRC_VIDEO;
      end else if (is_read && s_hit) begin
         src = SRC_SPRITE;
      end else begin
         src = SRC_LOCAL;
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // pick memory data on the cycle it leaves the read register
   always_comb begin
      case (s1_src_ff)
         SRC_VIDEO:  out_byte_in = v_rdata;
         SRC_SPRITE: out_byte_in = s_rdata;
         default:    out_byte_in = s1_byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff  <= src;
         s1_byte_ff <= status.rd_byte;
         s1_irq_ff  <= status.irq;
         s1_mode_ff <= status.mode;
         s1_line_ff <= status.line;
      end
      if (s1_adv) begin
         out_byte_ff <= out_byte_in;
         out_irq_ff  <= s1_irq_ff;
         out_mode_ff <= s1_mode_ff;
         out_line_ff <= s1_line_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.read_byte   = out_byte_ff;
   assign rsp_ch.vblank_irq  = out_irq_ff;
   assign rsp_ch.video_mode  = out_mode_ff;
   assign rsp_ch.line_number = out_line_ff;

   a_irq_in_vblank: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.vblank_irq
      |-> rsp_ch.video_mode == MODE_VBLANK
          && (rsp_ch.line_number == VBLANK_LINE
              || rsp_ch.line_number == VBLANK_LINE + 8'd1))
      else $error("vblank pulse outside vblank");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv
      |=> s1_valid_ff && $stable(s1_src_ff) && $stable(s1_line_ff) && $stable(s1_byte_ff))
      else $error("stalled read stage lost its transaction");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ch.ready |-> !accept)
      else $error("transaction taken with both stages full");

endmodule

`default_nettype wire

// ===== design/vult_ram.sv =====
`default_nettype none

module vult_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/vult_regs.sv =====
`default_nettype none

module vult_regs (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [1:0]                 action,
   input  wire logic [15:0]                address,
   input  wire logic [7:0]                 write_byte,
   input  wire logic [8:0]                 elapsed_cycles,
   output      vult_pkg::regs_status_type  status
);
   import vult_pkg::*;

   logic [7:0]       regs_ff [REG_COUNT];
   logic [7:0]       regs_in [REG_COUNT];
   logic [DOT_W-1:0] dot_ff;
   logic [DOT_W-1:0] dot_in;

   logic [15:0]       reg_off;
   logic [REG_AW-1:0] reg_idx;
   logic              reg_hit;
   logic [SUM_W-1:0]  dot_sum;
   logic              wrap_one;
   logic              wrap_two;
   logic [DOT_W-1:0]  dot_next;
   logic [8:0]        step_a;
   logic [8:0]        step_b;
   logic [7:0]        line_tick;
   logic              irq_tick;
   logic              irq;
   logic [7:0]        rd_byte;

   // {irq, next line}: advance one line, flag vblank entry, wrap at the last line
   function automatic logic [8:0] step_line(input logic [7:0] line);
      logic [7:0] nxt;
      nxt = line + 8'd1;
      return {nxt == VBLANK_LINE, (nxt == LAST_LINE_WRAP) ? 8'd0 : nxt};
   endfunction

   function automatic video_mode_type mode_of(input logic [7:0] line,
                                              input logic [DOT_W-1:0] dot);
      video_mode_type m;
      if (line >= VBLANK_LINE) begin
         m = MODE_VBLANK;
      end else if (dot < SCAN_END) begin
         m = MODE_SCAN;
      end else if (dot < DRAW_END) begin
         m = MODE_DRAW;
      end else begin
         m = MODE_HBLANK;
      end
      return m;
   endfunction

   assign reg_off = address - REG_BASE;
   assign reg_idx = reg_off[REG_AW-1:0];
   assign reg_hit = (address >= REG_BASE) && (address <= REG_LAST);

   // a tick finishes at most two lines: dot stays below one line, tick below 512
   assign dot_sum  = SUM_W'(dot_ff) + SUM_W'(elapsed_cycles);
   assign wrap_two = dot_sum >= SUM_W'(2 * DOTS_PER_LINE);
   assign wrap_one = dot_sum >= SUM_W'(DOTS_PER_LINE);
   assign step_a   = step_line(regs_ff[REG_LINE]);
   assign step_b   = step_line(step_a[7:0]);

   always_comb begin
      if (wrap_two) begin
         dot_next  = DOT_W'(dot_sum - SUM_W'(2 * DOTS_PER_LINE));
         line_tick = step_b[7:0];
         irq_tick  = step_a[8] | step_b[8];
      end else if (wrap_one) begin
         dot_next  = DOT_W'(dot_sum - SUM_W'(DOTS_PER_LINE));
         line_tick = step_a[7:0];
         irq_tick  = step_a[8];
      end else begin
         dot_next  = DOT_W'(dot_sum);
         line_tick = regs_ff[REG_LINE];
         irq_tick  = 1'b0;
      end
   end

   always_comb begin
      regs_in = regs_ff;
      dot_in  = dot_ff;
      irq     = 1'b0;
      rd_byte = BYTE_UNMAPPED;
      unique case (action)
         ACT_READ: begin
            if (reg_hit) begin
               rd_byte = regs_ff[reg_idx];
            end
         end
         ACT_WRITE: begin
            if (accept && reg_hit) begin
               if (reg_idx == REG_STAT) begin
                  // mode bits belong to the timing logic
                  regs_in[reg_idx] = {write_byte[7:2], regs_ff[reg_idx][1:0]};
               end else begin
                  regs_in[reg_idx] = write_byte;
               end
            end
         end
         ACT_TICK: begin
            if (accept) begin
               dot_in                 = dot_next;
               regs_in[REG_LINE]      = line_tick;
               regs_in[REG_STAT][1:0] = mode_of(line_tick, dot_next);
               irq                    = irq_tick;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= 8'd0;
         end
         dot_ff <= '0;
      end else begin
         regs_ff <= regs_in;
         dot_ff  <= dot_in;
      end
   end

   assign status.rd_byte = rd_byte;
   assign status.irq     = irq;
   assign status.mode    = video_mode_type'(regs_in[REG_STAT][1:0]);
   assign status.line    = regs_in[REG_LINE];

   a_dot_in_line: assert property (@(posedge clock) disable iff (reset)
      dot_ff < DOT_W'(DOTS_PER_LINE))
      else $error("dot counter past end of line");

   a_tick_mode: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_TICK
      |=> regs_ff[REG_STAT][1:0] == mode_of(regs_ff[REG_LINE], dot_ff))
      else $error("mode bits disagree with line and dot after tick");

   a_write_keeps_timing: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_WRITE
      |=> $stable(dot_ff) && regs_ff[REG_STAT][1:0] == $past(regs_ff[REG_STAT][1:0]))
      else $error("bus write disturbed timing state");

endmodule

`default_nettype wire
